@@ rtl/core/mts_pkg.sv @@
// Shared types and constants of the multi-timer scheduler.
package mts_pkg;

   // command codes on req_cmd
   localparam logic [2:0] CMD_ADD       = 3'd0;
   localparam logic [2:0] CMD_DEL_ID    = 3'd1;
   localparam logic [2:0] CMD_DEL_OWNER = 3'd2;
   localparam logic [2:0] CMD_DEL_PARAM = 3'd3;
   localparam logic [2:0] CMD_TICK      = 3'd4;

   // result kinds on rsp_kind
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_DEL    = 2'd1;
   localparam logic [1:0] KIND_EXPIRE = 2'd2;

   localparam logic [31:0] MIN_PERIOD     = 32'd10;
   localparam logic [15:0] REPEAT_FOREVER = 16'hFFFF;
   localparam logic [47:0] TIME_MAX       = 48'hFFFF_FFFF_FFFF;
   localparam logic [5:0]  REMOVED_MAX    = 6'd63;

   // one timer table entry
   typedef struct packed {
      logic [31:0] id;
      logic [15:0] owner;
      logic [31:0] param;
      logic [31:0] period;
      logic [15:0] repeat_lim;
      logic [31:0] count;
      logic [47:0] start;
      logic [47:0] due;
      logic [31:0] order;
   } entry_type;

endpackage

@@ rtl/core/mts_slot_ram.sv @@
// Timer table storage: one write port, one registered read port.
module mts_slot_ram #(
   parameter int DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  mts_pkg::entry_type         wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output mts_pkg::entry_type         rd_data
);

   mts_pkg::entry_type mem [DEPTH];
   mts_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mts_due_unit.sv @@
// Due time unit: start + period * (count + 1), saturated, in registered stages.
module mts_due_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [31:0] period,
   input  logic [31:0] count,
   input  logic [47:0] start,
   output logic        done,
   output logic [47:0] due
);

   logic        v1_ff;
   logic [63:0] mul_ff;
   logic [31:0] per_ff;
   logic [47:0] st_ff;
   logic        done_ff;
   logic [47:0] due_ff;
   logic [64:0] prod;
   logic [64:0] sum;

   // stage 1: period * count; the extra period is added in stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= go;
      end
      mul_ff <= 64'(period) * 64'(count);
      per_ff <= period;
      st_ff  <= start;
   end

   assign prod = {1'b0, mul_ff} + {33'd0, per_ff};
   assign sum  = {17'd0, st_ff} + prod;

   // stage 2: add start and saturate at the top of the time range
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= v1_ff;
      end
      due_ff <= (sum[64:48] != 17'd0) ? mts_pkg::TIME_MAX : sum[47:0];
   end

   assign done = done_ff;
   assign due  = due_ff;

endmodule

@@ rtl/core/multi_timer_scheduler_top.sv @@
// Multi-timer scheduler: timer table with add, delete and tick commands.
//
// Commands enter on the req_ channel (valid/ready); req_ready is high only
// while the sequencer is idle. Results leave on the rsp_ channel from an
// output register; rsp_last marks the final beat of a command. Add and
// delete give one beat, a tick gives up to MAX_FIRES_PER_TICK expiry beats
// (none when no timer is due), unknown commands give none.
// All work goes through one table read per cycle and one shared
// multiply/saturating-add unit:
//   delete:  one pass over the table
//   add:     a free slot search over the valid bits, then the due unit;
//            after the id counter has wrapped, each id candidate costs one
//            more table pass, at most NUM_TIMERS + 2 candidates
//   tick:    one table pass per fired timer plus its fire, rearm and next steps,
//            and one closing pass unless MAX_FIRES_PER_TICK fire
// Reset empties the table and clears the id and arming counters; there is
// no clearing pass. When the receiver holds rsp_ready low the sequencer
// waits with the beat in the output register and resumes once it is taken.
module multi_timer_scheduler_top #(
   parameter int NUM_TIMERS         = 32,
   parameter int MAX_FIRES_PER_TICK = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_period_ms,
   input  logic [15:0] req_owner,
   input  logic [31:0] req_user_param,
   input  logic signed [15:0] req_repeat_limit,
   input  logic [31:0] req_target_id,
   input  logic [47:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_timer_id,
   output logic [31:0] rsp_fired_param,
   output logic [31:0] rsp_fire_count,
   output logic [5:0]  rsp_removed_count,
   output logic        rsp_ok,
   output logic        rsp_last
);

   localparam int IDXW = $clog2(NUM_TIMERS);
   localparam int CW   = $clog2(NUM_TIMERS + 1);
   localparam int AW   = $clog2(NUM_TIMERS + 2);
   localparam int FW   = $clog2(MAX_FIRES_PER_TICK + 1);
   localparam logic [CW-1:0] SCAN_END  = CW'(NUM_TIMERS);
   localparam logic [AW-1:0] ATT_LAST  = AW'(NUM_TIMERS + 1);
   localparam logic [FW-1:0] FIRES_MAX = FW'(MAX_FIRES_PER_TICK);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_FREE     = 4'd1;
   localparam logic [3:0] S_ID_TEST  = 4'd2;
   localparam logic [3:0] S_ID_SCAN  = 4'd3;
   localparam logic [3:0] S_ADD_GO   = 4'd4;
   localparam logic [3:0] S_ADD_WAIT = 4'd5;
   localparam logic [3:0] S_DEL      = 4'd6;
   localparam logic [3:0] S_TSCAN    = 4'd7;
   localparam logic [3:0] S_TFIRE    = 4'd8;
   localparam logic [3:0] S_TARM     = 4'd9;
   localparam logic [3:0] S_TNEXT    = 4'd10;
   localparam logic [3:0] S_RESP     = 4'd11;

   // latched command
   logic [2:0]  cmd_ff;
   logic [31:0] period_ff;
   logic [15:0] owner_ff;
   logic [31:0] param_ff;
   logic [15:0] repeat_ff;
   logic [31:0] target_ff;
   logic [47:0] now_ff;

   logic [3:0]            state_ff, state_in;
   logic [3:0]            ret_ff, ret_in;
   logic [CW-1:0]         scan_idx_ff, scan_idx_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDXW-1:0]       rd_idx_ff, rd_idx_in;
   logic [NUM_TIMERS-1:0] valid_ff, valid_in;
   logic [IDXW-1:0]       slot_ff, slot_in;
   logic [31:0]           cand_ff, cand_in;
   logic [AW-1:0]         att_ff, att_in;
   logic                  inuse_ff, inuse_in;
   logic [31:0]           next_id_ff, next_id_in;
   logic                  wrapped_ff, wrapped_in;
   logic [31:0]           order_ff, order_in;
   logic [5:0]            removed_ff, removed_in;
   logic                  have_best_ff, have_best_in;
   logic [IDXW-1:0]       best_idx_ff, best_idx_in;
   mts_pkg::entry_type    best_ff, best_in;
   logic [FW-1:0]         fires_ff, fires_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic [31:0]           rsp_id_ff, rsp_id_in;
   logic [31:0]           rsp_param_ff, rsp_param_in;
   logic [31:0]           rsp_cnt_ff, rsp_cnt_in;
   logic [5:0]            rsp_rem_ff, rsp_rem_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic                  rsp_last_ff, rsp_last_in;

   // table and due unit hookups
   logic                  ram_wr_en;
   logic [IDXW-1:0]       ram_wr_addr;
   mts_pkg::entry_type    ram_wr_data;
   logic                  ram_rd_en;
   mts_pkg::entry_type    rd_entry;
   logic                  due_go;
   logic [31:0]           due_period;
   logic [31:0]           due_count;
   logic [47:0]           due_start;
   logic                  due_done;
   logic [47:0]           due_val;

   logic                  scanning;
   logic                  scan_done;
   logic                  rd_live;
   logic                  hit;
   logic                  better;
   logic [31:0]           pmax;
   logic [31:0]           cnt_new;
   logic                  rearm;
   logic                  found;

   mts_slot_ram #(.DEPTH(NUM_TIMERS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff[IDXW-1:0]),
      .rd_data (rd_entry)
   );

   mts_due_unit u_due (
      .clock  (clock),
      .reset  (reset),
      .go     (due_go),
      .period (due_period),
      .count  (due_count),
      .start  (due_start),
      .done   (due_done),
      .due    (due_val)
   );

   assign req_ready = (state_ff == S_IDLE);

   // helpers
   assign pmax      = (period_ff < mts_pkg::MIN_PERIOD) ? mts_pkg::MIN_PERIOD : period_ff;
   assign cnt_new   = best_ff.count + 32'd1;
   assign rearm     = (best_ff.repeat_lim == mts_pkg::REPEAT_FOREVER) ||
                      (!best_ff.repeat_lim[15] && (best_ff.repeat_lim != 16'd0) &&
                       (cnt_new < {16'd0, best_ff.repeat_lim}));
   assign scanning  = (state_ff == S_DEL) || (state_ff == S_TSCAN) ||
                      (state_ff == S_ID_SCAN);
   assign scan_done = (scan_idx_ff == SCAN_END) && !rd_vld_ff;
   assign rd_live   = rd_vld_ff && valid_ff[rd_idx_ff];
   assign found     = have_best_ff && (best_ff.due <= now_ff);

   // delete match on the entry coming out of the table
   always_comb begin
      unique case (cmd_ff)
         mts_pkg::CMD_DEL_ID:    hit = (rd_entry.id == target_ff);
         mts_pkg::CMD_DEL_OWNER: hit = (owner_ff != 16'd0) && (rd_entry.owner == owner_ff);
         mts_pkg::CMD_DEL_PARAM: hit = (rd_entry.param == param_ff);
         default:                hit = 1'b0;
      endcase
   end

   // earliest due, ties to the oldest arming
   assign better = !have_best_ff || (rd_entry.due < best_ff.due) ||
                   ((rd_entry.due == best_ff.due) &&
                    ((order_ff - rd_entry.order) > (order_ff - best_ff.order)));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      scan_idx_in  = scan_idx_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      valid_in     = valid_ff;
      slot_in      = slot_ff;
      cand_in      = cand_ff;
      att_in       = att_ff;
      inuse_in     = inuse_ff;
      next_id_in   = next_id_ff;
      wrapped_in   = wrapped_ff;
      order_in     = order_ff;
      removed_in   = removed_ff;
      have_best_in = have_best_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      fires_in     = fires_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_param_in = rsp_param_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = best_idx_ff;
      ram_wr_data  = best_ff;
      ram_rd_en    = 1'b0;
      due_go       = 1'b0;
      due_period   = best_ff.period;
      due_count    = cnt_new;
      due_start    = best_ff.start;

      // table pass: one read issued per cycle
      if (scanning && (scan_idx_ff != SCAN_END)) begin
         ram_rd_en   = 1'b1;
         rd_vld_in   = 1'b1;
         rd_idx_in   = scan_idx_ff[IDXW-1:0];
         scan_idx_in = scan_idx_ff + CW'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               scan_idx_in  = '0;
               removed_in   = '0;
               have_best_in = 1'b0;
               fires_in     = '0;
               rsp_kind_in  = mts_pkg::KIND_ADD;
               rsp_id_in    = '0;
               rsp_param_in = '0;
               rsp_cnt_in   = '0;
               rsp_rem_in   = '0;
               rsp_ok_in    = 1'b0;
               rsp_last_in  = 1'b1;
               ret_in       = S_IDLE;
               priority if (req_cmd == mts_pkg::CMD_ADD) begin
                  if (req_owner == 16'd0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_RESP;
                  end else begin
                     state_in = S_FREE;
                  end
               end else if ((req_cmd == mts_pkg::CMD_DEL_ID) ||
                            (req_cmd == mts_pkg::CMD_DEL_OWNER) ||
                            (req_cmd == mts_pkg::CMD_DEL_PARAM)) begin
                  state_in = S_DEL;
               end else if (req_cmd == mts_pkg::CMD_TICK) begin
                  state_in = S_TSCAN;
               end
            end
         end

         // lowest free slot, one valid bit a cycle
         S_FREE: begin
            if (scan_idx_ff == SCAN_END) begin
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end else if (!valid_ff[scan_idx_ff[IDXW-1:0]]) begin
               slot_in = scan_idx_ff[IDXW-1:0];
               cand_in = next_id_ff + 32'd1;
               if (((next_id_ff + 32'd1) == 32'd0) || wrapped_ff) begin
                  wrapped_in = 1'b1;
                  att_in     = '0;
                  state_in   = S_ID_TEST;
               end else begin
                  state_in = S_ADD_GO;
               end
            end else begin
               scan_idx_in = scan_idx_ff + CW'(1);
            end
         end

         S_ID_TEST: begin
            if (cand_ff != 32'd0) begin
               scan_idx_in = '0;
               inuse_in    = 1'b0;
               state_in    = S_ID_SCAN;
            end else begin
               cand_in  = cand_ff + 32'd1;
               att_in   = att_ff + AW'(1);
               state_in = (att_ff == ATT_LAST) ? S_ADD_GO : S_ID_TEST;
            end
         end

         S_ID_SCAN: begin
            if (rd_live && (rd_entry.id == cand_ff)) begin
               inuse_in = 1'b1;
            end
            if (scan_done) begin
               if (!inuse_ff) begin
                  state_in = S_ADD_GO;
               end else begin
                  cand_in  = cand_ff + 32'd1;
                  att_in   = att_ff + AW'(1);
                  state_in = (att_ff == ATT_LAST) ? S_ADD_GO : S_ID_TEST;
               end
            end
         end

         S_ADD_GO: begin
            next_id_in = cand_ff;
            due_go     = 1'b1;
            due_period = pmax;
            due_count  = '0;
            due_start  = now_ff;
            state_in   = S_ADD_WAIT;
         end

         S_ADD_WAIT: begin
            if (due_done) begin
               ram_wr_en               = 1'b1;
               ram_wr_addr             = slot_ff;
               ram_wr_data.id          = cand_ff;
               ram_wr_data.owner       = owner_ff;
               ram_wr_data.param       = param_ff;
               ram_wr_data.period      = pmax;
               ram_wr_data.repeat_lim  = repeat_ff;
               ram_wr_data.count       = '0;
               ram_wr_data.start       = now_ff;
               ram_wr_data.due         = due_val;
               ram_wr_data.order       = order_ff;
               valid_in[slot_ff]       = 1'b1;
               order_in                = order_ff + 32'd1;
               rsp_id_in               = cand_ff;
               rsp_valid_in            = 1'b1;
               state_in                = S_RESP;
            end
         end

         S_DEL: begin
            if (rd_live && hit) begin
               valid_in[rd_idx_ff] = 1'b0;
               if (removed_ff != mts_pkg::REMOVED_MAX) begin
                  removed_in = removed_ff + 6'd1;
               end
            end
            if (scan_done) begin
               rsp_kind_in  = mts_pkg::KIND_DEL;
               rsp_rem_in   = removed_ff;
               rsp_ok_in    = (removed_ff != 6'd0);
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end
         end

         // earliest due timer, one entry a cycle
         S_TSCAN: begin
            if (rd_live && better) begin
               have_best_in = 1'b1;
               best_idx_in  = rd_idx_ff;
               best_in      = rd_entry;
            end
            if (scan_done) begin
               if (found) begin
                  if (fires_ff != '0) begin
                     rsp_last_in  = 1'b0;
                     rsp_valid_in = 1'b1;
                     ret_in       = S_TFIRE;
                     state_in     = S_RESP;
                  end else begin
                     state_in = S_TFIRE;
                  end
               end else if (fires_ff != '0) begin
                  rsp_last_in  = 1'b1;
                  rsp_valid_in = 1'b1;
                  ret_in       = S_IDLE;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         // fire: result beat is held until the next pass says if it is last
         S_TFIRE: begin
            best_in.count = cnt_new;
            rsp_kind_in   = mts_pkg::KIND_EXPIRE;
            rsp_id_in     = best_ff.id;
            rsp_param_in  = best_ff.param;
            rsp_cnt_in    = cnt_new;
            rsp_rem_in    = '0;
            rsp_ok_in     = 1'b0;
            fires_in      = fires_ff + FW'(1);
            if (rearm) begin
               due_go   = 1'b1;
               state_in = S_TARM;
            end else begin
               valid_in[best_idx_ff] = 1'b0;
               state_in              = S_TNEXT;
            end
         end

         S_TARM: begin
            if (due_done) begin
               ram_wr_en         = 1'b1;
               ram_wr_data.due   = due_val;
               ram_wr_data.order = order_ff;
               order_in          = order_ff + 32'd1;
               state_in          = S_TNEXT;
            end
         end

         S_TNEXT: begin
            if (fires_ff == FIRES_MAX) begin
               rsp_last_in  = 1'b1;
               rsp_valid_in = 1'b1;
               ret_in       = S_IDLE;
               state_in     = S_RESP;
            end else begin
               scan_idx_in  = '0;
               have_best_in = 1'b0;
               state_in     = S_TSCAN;
            end
         end

         // hold the beat until the receiver takes it
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ret_ff;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         next_id_ff   <= '0;
         wrapped_ff   <= 1'b0;
         order_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rd_vld_ff    <= rd_vld_in;
         valid_ff     <= valid_in;
         next_id_ff   <= next_id_in;
         wrapped_ff   <= wrapped_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      rd_idx_ff    <= rd_idx_in;
      slot_ff      <= slot_in;
      cand_ff      <= cand_in;
      att_ff       <= att_in;
      inuse_ff     <= inuse_in;
      removed_ff   <= removed_in;
      have_best_ff <= have_best_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      fires_ff     <= fires_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_param_ff <= rsp_param_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_rem_ff   <= rsp_rem_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_last_ff  <= rsp_last_in;
      if (req_valid && req_ready) begin
         cmd_ff    <= req_cmd;
         period_ff <= req_period_ms;
         owner_ff  <= req_owner;
         param_ff  <= req_user_param;
         repeat_ff <= req_repeat_limit;
         target_ff <= req_target_id;
         now_ff    <= req_now_ms;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_timer_id      = rsp_id_ff;
   assign rsp_fired_param   = rsp_param_ff;
   assign rsp_fire_count    = rsp_cnt_ff;
   assign rsp_removed_count = rsp_rem_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

@@ tb/multi_timer_scheduler_top_test.sv @@
// Testbench for the multi-timer scheduler: predicts every response beat and checks them in order.
`timescale 1ns / 1ps

module multi_timer_scheduler_top_test;

   localparam int NTIM       = 32;
   localparam int FIRE_MAX   = 5;
   localparam int CYCLE_CAP  = 600000;
   localparam int RAND_ITEMS = 157;
   localparam int HOLD_AT    = 50;
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN_AT   = 100;

   typedef struct {
      logic [2:0]         cmd;
      logic [31:0]        period;
      logic [15:0]        owner;
      logic [31:0]        param;
      logic signed [15:0] rep;
      logic [31:0]        target;
      logic [47:0]        now;
   } cmd_item_type;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] id;
      logic [31:0] param;
      logic [31:0] count;
      logic [5:0]  removed;
      logic        ok;
      logic        last;
   } rsp_beat_type;

   // timer table mirror and the queue of expected response beats
   class timer_scoreboard;
      bit                  live [NTIM];
      mts_pkg::entry_type  tbl [NTIM];
      logic [31:0]         arm_seq;
      logic [31:0]         id_ctr;
      bit                  id_wrap;
      rsp_beat_type        expected_beats[$];
      int                  errors;

      function void clear();
         foreach (live[i]) live[i] = 0;
         arm_seq = 0;
         id_ctr  = 0;
         id_wrap = 0;
         errors  = 0;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      // due = start + period*(count+1), saturated at the top of time
      function void arm(int s);
         logic [63:0] prod, room;
         prod = 64'(tbl[s].period) * (64'(tbl[s].count) + 64'd1);
         room = 64'(mts_pkg::TIME_MAX) - 64'(tbl[s].start);
         tbl[s].due   = (prod > room) ? mts_pkg::TIME_MAX : tbl[s].start + prod[47:0];
         tbl[s].order = arm_seq;
         arm_seq++;
      endfunction

      function bit id_busy(logic [31:0] id);
         foreach (live[i]) if (live[i] && tbl[i].id == id) return 1;
         return 0;
      endfunction

      function logic [31:0] pick_live_id();
         logic [31:0] ids[$];
         foreach (live[i]) if (live[i]) ids.insert(ids.size(), tbl[i].id);
         if (ids.size() == 0) return $urandom;
         return ids[$urandom_range(0, ids.size() - 1)];
      endfunction

      function logic [31:0] add_timer(cmd_item_type it);
         int s;
         s = -1;
         if (it.owner == 0) return 0;
         for (int i = 0; i < NTIM; i++) if (!live[i]) begin
            s = i;
            break;
         end
         if (s < 0) return 0;
         id_ctr++;
         if (id_ctr == 0 || id_wrap) begin
            id_wrap = 1;
            for (int k = 0; k <= NTIM + 1; k++) begin
               if (id_ctr != 0 && !id_busy(id_ctr)) break;
               id_ctr++;
            end
         end
         live[s]           = 1;
         tbl[s].id         = id_ctr;
         tbl[s].owner      = it.owner;
         tbl[s].param      = it.param;
         tbl[s].period     = (it.period < mts_pkg::MIN_PERIOD) ? mts_pkg::MIN_PERIOD :
                             it.period;
         tbl[s].repeat_lim = it.rep;
         tbl[s].count      = 0;
         tbl[s].start      = it.now;
         arm(s);
         return id_ctr;
      endfunction

      // fire up to FIRE_MAX due timers, earliest first, older arming wins ties
      function void tick(logic [47:0] now);
         rsp_beat_type b;
         int n, best;
         logic [31:0] rep_s;
         n = 0;
         while (n < FIRE_MAX) begin
            best = -1;
            for (int i = 0; i < NTIM; i++) begin
               if (!live[i]) continue;
               if (best < 0 || tbl[i].due < tbl[best].due ||
                   (tbl[i].due == tbl[best].due &&
                    32'(arm_seq - tbl[i].order) > 32'(arm_seq - tbl[best].order)))
                  best = i;
            end
            if (best < 0 || tbl[best].due > now) break;
            tbl[best].count++;
            b = '{mts_pkg::KIND_EXPIRE, tbl[best].id, tbl[best].param, tbl[best].count,
                  6'd0, 1'b0, 1'b0};
            expected_beats.insert(expected_beats.size(), b);
            n++;
            rep_s = 32'(signed'(tbl[best].repeat_lim));
            if (tbl[best].repeat_lim == mts_pkg::REPEAT_FOREVER ||
                (!rep_s[31] && rep_s != 0 && tbl[best].count < rep_s))
               arm(best);
            else
               live[best] = 0;
         end
         if (n > 0) expected_beats[$].last = 1;
      endfunction

      function void note_input(cmd_item_type it);
         rsp_beat_type b;
         int removed;
         bit hit;
         removed = 0;
         case (it.cmd)
            mts_pkg::CMD_ADD: begin
               b = '{mts_pkg::KIND_ADD, add_timer(it), 32'd0, 32'd0, 6'd0, 1'b0, 1'b1};
               expected_beats.insert(expected_beats.size(), b);
            end
            mts_pkg::CMD_DEL_ID, mts_pkg::CMD_DEL_OWNER, mts_pkg::CMD_DEL_PARAM: begin
               for (int i = 0; i < NTIM; i++) begin
                  if (!live[i]) continue;
                  if (it.cmd == mts_pkg::CMD_DEL_ID)
                     hit = (tbl[i].id == it.target);
                  else if (it.cmd == mts_pkg::CMD_DEL_OWNER)
                     hit = (it.owner != 0 && tbl[i].owner == it.owner);
                  else
                     hit = (tbl[i].param == it.param);
                  if (hit) begin
                     live[i] = 0;
                     removed++;
                  end
               end
               b = '{mts_pkg::KIND_DEL, 32'd0, 32'd0, 32'd0,
                     (removed > 63) ? mts_pkg::REMOVED_MAX : 6'(removed), removed > 0, 1'b1};
               expected_beats.insert(expected_beats.size(), b);
            end
            mts_pkg::CMD_TICK: tick(it.now);
            default: ;
         endcase
      endfunction

      task check_result(rsp_beat_type got);
         rsp_beat_type e;
         if (expected_beats.size() == 0) begin
            report($sformatf("unexpected beat kind=%0d id=%0d", got.kind, got.id));
            return;
         end
         e = expected_beats[0];
         expected_beats.delete(0);
         if (got.kind !== e.kind)
            report($sformatf("kind got %0d exp %0d", got.kind, e.kind));
         if (got.id !== e.id)
            report($sformatf("timer_id got %0d exp %0d", got.id, e.id));
         if (got.param !== e.param)
            report($sformatf("fired_param got %h exp %h", got.param, e.param));
         if (got.count !== e.count)
            report($sformatf("fire_count got %0d exp %0d", got.count, e.count));
         if (got.removed !== e.removed)
            report($sformatf("removed_count got %0d exp %0d", got.removed, e.removed));
         if (got.ok !== e.ok)
            report($sformatf("ok got %b exp %b", got.ok, e.ok));
         if (got.last !== e.last)
            report($sformatf("last got %b exp %b", got.last, e.last));
      endtask
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [2:0]         req_cmd = '0;
   logic [31:0]        req_period_ms = '0;
   logic [15:0]        req_owner = '0;
   logic [31:0]        req_user_param = '0;
   logic signed [15:0] req_repeat_limit = '0;
   logic [31:0]        req_target_id = '0;
   logic [47:0]        req_now_ms = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [1:0]         rsp_kind;
   logic [31:0]        rsp_timer_id;
   logic [31:0]        rsp_fired_param;
   logic [31:0]        rsp_fire_count;
   logic [5:0]         rsp_removed_count;
   logic               rsp_ok;
   logic               rsp_last;

   timer_scoreboard sb = new();
   int          cycle_count = 0;
   int          hold_cycles = 0;
   bit          hold_done = 0;
   int          items_sent = 0;
   int          burst_left = 0;
   logic [47:0] clock_ms = 0;

   multi_timer_scheduler_top DUT (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: one long hold once enough items went in, else a rotation of always, mostly and seldom ready
   always @(posedge clock) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
         hold_done   <= 1;
         hold_cycles <= HOLD_LEN;
         rsp_ready   <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 0;
      end else begin
         case ((cycle_count / 64) % 3)
            0: rsp_ready <= 1;
            1: rsp_ready <= ($urandom_range(0, 9) < 7);
            default: rsp_ready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result('{rsp_kind, rsp_timer_id, rsp_fired_param, rsp_fire_count,
                           rsp_removed_count, rsp_ok, rsp_last});
   end

   // one beat on the request channel; bursts with random gaps in between
   task automatic send(input cmd_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1;
      req_cmd          <= it.cmd;
      req_period_ms    <= it.period;
      req_owner        <= it.owner;
      req_user_param   <= it.param;
      req_repeat_limit <= it.rep;
      req_target_id    <= it.target;
      req_now_ms       <= it.now;
      do @(posedge clock); while (!req_ready);
      sb.note_input(it);
   endtask

   task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] period,
                           input logic [15:0] owner, input logic [31:0] param,
                           input logic signed [15:0] rep, input logic [31:0] target,
                           input logic [47:0] now);
      cmd_item_type it;
      it = '{cmd, period, owner, param, rep, target, now};
      send(it);
   endtask

   task automatic drain();
      req_valid <= 0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // random command: mostly timers with short periods on a moving clock
   function automatic cmd_item_type make_random();
      cmd_item_type it;
      int sel;
      it.period = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 120);
      it.owner  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      it.param  = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 7));
      case ($urandom_range(0, 4))
         0: it.rep = -16'sd1;
         1: it.rep = 16'sd0;
         2: it.rep = 16'($urandom);
         default: it.rep = 16'($urandom_range(1, 5));
      endcase
      it.target = ($urandom_range(0, 3) == 0) ? $urandom : sb.pick_live_id();
      it.now = clock_ms;
      sel = $urandom_range(0, 99);
      if (sel < 35) it.cmd = mts_pkg::CMD_ADD;
      else if (sel < 72) begin
         it.cmd = mts_pkg::CMD_TICK;
         clock_ms = clock_ms + 48'($urandom_range(0, 60));
         it.now = ($urandom_range(0, 40) == 0) ? 48'({$urandom, $urandom}) : clock_ms;
      end
      else if (sel < 82) it.cmd = mts_pkg::CMD_DEL_ID;
      else if (sel < 89) it.cmd = mts_pkg::CMD_DEL_OWNER;
      else if (sel < 95) it.cmd = mts_pkg::CMD_DEL_PARAM;
      else it.cmd = 3'($urandom_range(5, 7));
      return it;
   endfunction

   initial begin
      sb.clear();
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: null owner, minimum period, saturated due time, repeat variants
      send_cmd(mts_pkg::CMD_ADD, 32'd50, 16'd0, 32'd1, -16'sd1, 32'd0, 48'd0);
      send_cmd(mts_pkg::CMD_ADD, 32'd0, 16'd1, 32'hFFFF_FFFF, 16'sd2, 32'd0, 48'd0);
      send_cmd(mts_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'd2, 16'sd32767, 32'd0,
               mts_pkg::TIME_MAX - 48'd5);
      send_cmd(mts_pkg::CMD_ADD, 32'd10, 16'd2, 32'd3, 16'sd0, 32'd0, 48'd0);
      send_cmd(mts_pkg::CMD_ADD, 32'd10, 16'd2, 32'd3, -16'sd5, 32'd0, 48'd0);
      send_cmd(mts_pkg::CMD_ADD, 32'd10, 16'd3, 32'd4, -16'sd1, 32'hFFFF_FFFF, 48'd0);
      send_cmd(mts_pkg::CMD_TICK, 32'd0, 16'd0, 32'd0, 16'sd0, 32'd0, 48'd5);
      send_cmd(mts_pkg::CMD_TICK, 32'd0, 16'd0, 32'd0, 16'sd0, 32'd0, 48'd10);
      send_cmd(mts_pkg::CMD_TICK, 32'd0, 16'd0, 32'd0, 16'sd0, 32'd0, 48'd30);
      send_cmd(mts_pkg::CMD_DEL_ID, 32'd0, 16'd0, 32'd0, 16'sd0, 32'd6, 48'd0);
      send_cmd(mts_pkg::CMD_DEL_ID, 32'd0, 16'd0, 32'd0, 16'sd0, 32'hFFFF_FFFF, 48'd0);
      send_cmd(mts_pkg::CMD_DEL_OWNER, 32'd0, 16'd0, 32'd0, 16'sd0, 32'd0, 48'd0);
      send_cmd(mts_pkg::CMD_DEL_PARAM, 32'd0, 16'd0, 32'hFFFF_FFFF, 16'sd0, 32'd0, 48'd0);
      for (int c = 5; c <= 7; c++)
         send_cmd(3'(c), 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, -16'sd1, 32'hFFFF_FFFF,
                  mts_pkg::TIME_MAX);
      // fill the table past its capacity, then clear it by owner
      for (int i = 0; i < NTIM + 2; i++)
         send_cmd(mts_pkg::CMD_ADD, 32'd1000, 16'd9, 32'(i), 16'sd1, 32'd0, 48'd100);
      send_cmd(mts_pkg::CMD_TICK, 32'd0, 16'd0, 32'd0, 16'sd0, 32'd0, mts_pkg::TIME_MAX);
      send_cmd(mts_pkg::CMD_DEL_OWNER, 32'd0, 16'd9, 32'd0, 16'sd0, 32'd0, 48'd0);
      send_cmd(mts_pkg::CMD_DEL_OWNER, 32'd0, 16'hFFFF, 32'd0, 16'sd0, 32'd0, 48'd0);
      drain();
      clock_ms = 48'd200;

      // random part, with a long receiver hold and a full drain on the way
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == DRAIN_AT) drain();
         items_sent = n;
         send(make_random());
      end

      drain();
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
